// ===== rtl/owb_pkg.sv =====
// Shared types, codes and helper functions of the 1-Wire bus master.
`timescale 1ns / 1ps

package owb_pkg;

    // Widths
    localparam int US_W       = 10;
    localparam int CPU_W      = 8;
    localparam int DUR_W      = 10;
    localparam int CMP_W      = ((US_W > DUR_W) ? US_W : DUR_W) + 1;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;
    localparam int RES_W      = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    // Phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_W_LOW    = 4'd4;
    localparam logic [3:0] PH_W_REL    = 4'd5;
    localparam logic [3:0] PH_R_LOW    = 4'd6;
    localparam logic [3:0] PH_R_WAIT   = 4'd7;
    localparam logic [3:0] PH_R_TAIL   = 4'd8;

    // Operation codes
    localparam logic [2:0] OP_RESET = 3'd0;
    localparam logic [2:0] OP_WBYTE = 3'd1;
    localparam logic [2:0] OP_RBYTE = 3'd2;
    localparam logic [2:0] OP_WBIT  = 3'd3;
    localparam logic [2:0] OP_RBIT  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW_US      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT_US  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY_US = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW_US      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW_US       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE_US    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL_US      = 4'd7;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [CPU_W-1:0] clocks_per_us;
        logic [DUR_W-1:0] reset_low_us;
        logic [DUR_W-1:0] presence_wait_us;
        logic [DUR_W-1:0] reset_recovery_us;
        logic [DUR_W-1:0] short_low_us;
        logic [DUR_W-1:0] long_low_us;
        logic [DUR_W-1:0] read_sample_us;
        logic [DUR_W-1:0] read_tail_us;
    } cfg_t;

    // Last member sits in the lowest bits
    typedef struct packed {
        logic [7:0] crc_value;
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    // Reflected CRC-8 over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/owb_core.sv =====
// Slot sequencer of the 1-Wire master: prescaler, phase timer, shifter and CRC.
`timescale 1ns / 1ps

module owb_core
    import owb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       cmd_valid,
    input  logic [2:0] operation,
    input  logic [7:0] write_data,
    input  logic       line_level,
    input  cfg_t       cfg,
    output res_t       res_next
);

    logic [3:0]      phase_reg, phase_next;
    logic [CPU_W-1:0] prescale_reg, prescale_next;
    logic [US_W-1:0] us_count_reg, us_count_next;
    logic [2:0]      bit_index_reg, bit_index_next;
    logic [7:0]      shift_reg, shift_next;
    logic [7:0]      crc_reg, crc_next;
    logic            presence_reg, presence_next;
    logic [2:0]      current_op_reg, current_op_next;
    logic [7:0]      read_data_reg, read_data_next;
    logic [DUR_W-1:0] phase_len;
    logic            done;

    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:  phase_len = cfg.reset_low_us;
            PH_RST_WAIT: phase_len = cfg.presence_wait_us;
            PH_RST_REC:  phase_len = cfg.reset_recovery_us;
            PH_W_LOW:    phase_len = shift_reg[0] ? cfg.short_low_us : cfg.long_low_us;
            PH_W_REL:    phase_len = shift_reg[0] ? cfg.long_low_us : cfg.short_low_us;
            PH_R_LOW:    phase_len = cfg.short_low_us;
            PH_R_WAIT:   phase_len = cfg.read_sample_us;
            default:     phase_len = cfg.read_tail_us;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        prescale_next   = prescale_reg;
        us_count_next   = us_count_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        crc_next        = crc_reg;
        presence_next   = presence_reg;
        current_op_next = current_op_reg;
        read_data_next  = read_data_reg;
        done            = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd_valid && operation <= OP_RBIT)
            begin
                current_op_next = operation;
                prescale_next   = '0;
                us_count_next   = '0;
                bit_index_next  = '0;
                unique case (operation) inside
                    OP_RESET:
                    begin
                        crc_next   = '0;
                        phase_next = PH_RST_LOW;
                    end
                    OP_WBYTE, OP_WBIT:
                    begin
                        shift_next = write_data;
                        phase_next = PH_W_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_R_LOW;
                    end
                endcase
            end
        end
        else if (({1'b0, prescale_reg} + (CPU_W+1)'(1)) >= {1'b0, cfg.clocks_per_us})
        begin
            prescale_next = '0;
            if ((CMP_W'(us_count_reg) + CMP_W'(1)) >= CMP_W'(phase_len))
            begin
                us_count_next = '0;
                unique case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = ~line_level;
                        phase_next    = PH_RST_REC;
                    end
                    PH_W_LOW:    phase_next = PH_W_REL;
                    PH_W_REL:
                    begin
                        shift_next = shift_reg >> 1;
                        if (current_op_reg == OP_WBYTE && bit_index_reg != 3'd7)
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_W_LOW;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_R_LOW:    phase_next = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        shift_next = {line_level, shift_reg[7:1]};
                        phase_next = PH_R_TAIL;
                    end
                    PH_R_TAIL:
                    begin
                        if (current_op_reg == OP_RBYTE && bit_index_reg != 3'd7)
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_R_LOW;
                        end
                        else
                        begin
                            if (current_op_reg == OP_RBYTE)
                            begin
                                read_data_next = shift_reg;
                                crc_next       = crc8_byte(crc_reg, shift_reg);
                            end
                            else
                            begin
                                read_data_next = {7'd0, shift_reg[7]};
                            end
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        // reset recovery, and any stray code, ends the command
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
            else
            begin
                us_count_next = us_count_reg + US_W'(1);
            end
        end
        else
        begin
            prescale_next = prescale_reg + CPU_W'(1);
        end
    end

    always_comb
    begin
        res_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW) ||
                             (phase_next == PH_R_LOW);
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.presence  = presence_next;
        res_next.read_data = read_data_next;
        res_next.crc_value = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            prescale_reg   <= '0;
            us_count_reg   <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            crc_reg        <= '0;
            presence_reg   <= 1'b0;
            current_op_reg <= OP_RESET;
            read_data_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            prescale_reg   <= prescale_next;
            us_count_reg   <= us_count_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            crc_reg        <= crc_next;
            presence_reg   <= presence_next;
            current_op_reg <= current_op_next;
            read_data_reg  <= read_data_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("command finished but sequencer not idle");

    a_idle_prescale_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> prescale_reg == '0)
        else $error("prescaler left running while idle");

    a_bit_index_byte_op: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg != 3'd0 |-> current_op_reg == OP_WBYTE || current_op_reg == OP_RBYTE)
        else $error("bit index advanced outside a byte command");

    a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(crc_reg))
        else $error("CRC changed without a tick");
`endif

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// Output: the result of each accepted tick is registered into the output register.
// Throughput: one tick per cycle; the single output register lets a tick in whenever
// it is empty or being drained in the same cycle.
// Bus timing: each phase lasts duration * clocks_per_us accepted ticks, a zero value counting as one.
// Reset: rst_n clears the sequencer, CRC and output valid flag and loads register defaults.
`timescale 1ns / 1ps

module one_wire_bus_master
    import owb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tdata: cmd_valid[0], operation[3:1], write_data[11:4], line_level[12], zero[15:13]
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: drive_low[0], busy_res[1], done_res[2], presence[3], read_data[11:4],
    //        crc_value[19:12], zero[23:20]
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    res_t        res_next;
    res_t        out_data_reg;
    logic        out_valid_reg;
    logic        step;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clocks_per_us     <= CPU_W'(8);
            cfg_reg.reset_low_us      <= DUR_W'(480);
            cfg_reg.presence_wait_us  <= DUR_W'(70);
            cfg_reg.reset_recovery_us <= DUR_W'(410);
            cfg_reg.short_low_us      <= DUR_W'(2);
            cfg_reg.long_low_us       <= DUR_W'(60);
            cfg_reg.read_sample_us    <= DUR_W'(10);
            cfg_reg.read_tail_us      <= DUR_W'(50);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLOCKS_PER_US:     cfg_reg.clocks_per_us     <= cfg_data[CPU_W-1:0];
                REG_RESET_LOW_US:      cfg_reg.reset_low_us      <= cfg_data;
                REG_PRESENCE_WAIT_US:  cfg_reg.presence_wait_us  <= cfg_data;
                REG_RESET_RECOVERY_US: cfg_reg.reset_recovery_us <= cfg_data;
                REG_SHORT_LOW_US:      cfg_reg.short_low_us      <= cfg_data;
                REG_LONG_LOW_US:       cfg_reg.long_low_us       <= cfg_data;
                REG_READ_SAMPLE_US:    cfg_reg.read_sample_us    <= cfg_data;
                REG_READ_TAIL_US:      cfg_reg.read_tail_us      <= cfg_data;
                default:               ;  // drop writes to unknown registers
            endcase
        end
    end

    owb_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd_valid  (s_tdata[0]),
        .operation  (s_tdata[3:1]),
        .write_data (s_tdata[11:4]),
        .line_level (s_tdata[12]),
        .cfg        (cfg_reg),
        .res_next   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the transfer completes
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W-RES_W)'(0), out_data_reg};

endmodule

// ===== sim/one_wire_bus_master_tb.sv =====
// Self-checking testbench for the 1-Wire bus master: tick stream in, line state and status out.
`timescale 1ns / 1ps

module one_wire_bus_master_tb;
    import owb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINE_RANDOM    = -1;
    localparam int RANDOM_PHASES  = 3;
    localparam int TICKS_PER_PHASE = 20;
    localparam int DRAIN_BATCH    = 4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST     = REG_READ_TAIL_US;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

    // Last member sits in the lowest bits, matching the s_tdata layout
    typedef struct packed {
        logic       line_level;
        logic [7:0] write_data;
        logic [2:0] operation;
        logic       cmd_valid;
    } tick_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    one_wire_bus_master uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bus master state as the testbench sees it
    cfg_t             bus_cfg;
    logic [3:0]       ph;
    logic [7:0]       presc;
    logic [US_W-1:0]  usc;
    logic [2:0]       bit_idx;
    logic [7:0]       shreg;
    logic [7:0]       crc;
    logic [7:0]       last_rd;
    logic             pres;
    logic [2:0]       cur_op;

    tick_t pending_ticks[$];
    res_t  expected_outputs[$];
    tick_t tick_on_bus;
    res_t  got;
    res_t  want;
    int    ticks_queued;
    int    ticks_taken;
    int    mismatches;
    int    tx_hold;
    int    rx_hold;
    int    idle_cycles;
    bit    gaps_on;

    always #5 clk = ~clk;

    function automatic int phase_len();
        case (ph)
            PH_RST_LOW:  return bus_cfg.reset_low_us;
            PH_RST_WAIT: return bus_cfg.presence_wait_us;
            PH_RST_REC:  return bus_cfg.reset_recovery_us;
            PH_W_LOW:    return shreg[0] ? bus_cfg.short_low_us : bus_cfg.long_low_us;
            PH_W_REL:    return shreg[0] ? bus_cfg.long_low_us : bus_cfg.short_low_us;
            PH_R_LOW:    return bus_cfg.short_low_us;
            PH_R_WAIT:   return bus_cfg.read_sample_us;
            default:     return bus_cfg.read_tail_us;
        endcase
    endfunction

    // Dallas CRC-8, LSB first
    function automatic logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 8'h8C;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Close the current slot phase; returns 1 when the command completes
    function automatic bit end_phase(input logic line);
        case (ph)
            PH_RST_LOW:  ph = PH_RST_WAIT;
            PH_RST_WAIT:
            begin
                pres = !line;
                ph   = PH_RST_REC;
            end
            PH_W_LOW:    ph = PH_W_REL;
            PH_W_REL:
            begin
                shreg = shreg >> 1;
                if (cur_op == OP_WBYTE && bit_idx < 3'd7)
                begin
                    bit_idx = bit_idx + 3'd1;
                    ph      = PH_W_LOW;
                end
                else
                    return 1'b1;
            end
            PH_R_LOW:    ph = PH_R_WAIT;
            PH_R_WAIT:
            begin
                shreg = {line, shreg[7:1]};
                ph    = PH_R_TAIL;
            end
            PH_R_TAIL:
            begin
                if (cur_op == OP_RBYTE && bit_idx < 3'd7)
                begin
                    bit_idx = bit_idx + 3'd1;
                    ph      = PH_R_LOW;
                end
                else
                begin
                    if (cur_op == OP_RBYTE)
                    begin
                        last_rd = shreg;
                        crc     = fold_crc(crc, shreg);
                    end
                    else
                        last_rd = {7'b0, shreg[7]};
                    return 1'b1;
                end
            end
            default:     return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // Advance the master by one accepted tick and give the output it shows
    function automatic res_t bus_tick(input tick_t t);
        res_t r;
        bit   fin;
        fin = 1'b0;
        if (ph == PH_IDLE)
        begin
            if (t.cmd_valid && t.operation <= OP_RBIT)
            begin
                cur_op  = t.operation;
                presc   = '0;
                usc     = '0;
                bit_idx = '0;
                if (t.operation == OP_RESET)
                begin
                    crc = '0;
                    ph  = PH_RST_LOW;
                end
                else if (t.operation == OP_WBYTE || t.operation == OP_WBIT)
                begin
                    shreg = t.write_data;
                    ph    = PH_W_LOW;
                end
                else
                begin
                    shreg = '0;
                    ph    = PH_R_LOW;
                end
            end
        end
        else if (int'(presc) + 1 >= int'(bus_cfg.clocks_per_us))
        begin
            presc = '0;
            if (int'(usc) + 1 >= phase_len())
            begin
                usc = '0;
                fin = end_phase(t.line_level);
                if (fin)
                    ph = PH_IDLE;
            end
            else
                usc = usc + 1'b1;
        end
        else
            presc = presc + 1'b1;

        r.drive_low = (ph == PH_RST_LOW || ph == PH_W_LOW || ph == PH_R_LOW);
        r.busy_res  = (ph != PH_IDLE);
        r.done_res  = fin;
        r.presence  = pres;
        r.read_data = last_rd;
        r.crc_value = crc;
        return r;
    endfunction

    function automatic tick_t make_tick(input bit valid, input logic [2:0] op,
                                        input logic [7:0] wd, input int line);
        tick_t t;
        t.cmd_valid  = valid;
        t.operation  = op;
        t.write_data = wd;
        t.line_level = (line == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : line[0];
        return t;
    endfunction

    // Mostly legal commands, one in ten an unused operation code
    function automatic tick_t random_tick(input int line);
        logic [2:0] op;
        if ($urandom_range(0, 9) == 0)
            op = 3'(OP_RBIT + 1 + $urandom_range(0, 2));
        else
            op = 3'($urandom_range(0, 4));
        return make_tick($urandom_range(0, 3) == 0, op, 8'($urandom), line);
    endfunction

    task automatic queue_tick(input tick_t t);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Feed ticks until the master is idle, then let every output drain
    task automatic drain_to_idle(input bit noisy, input int line);
        forever
        begin
            wait (ticks_taken == ticks_queued);
            if (ph == PH_IDLE)
                break;
            repeat (DRAIN_BATCH)
            begin
                if (noisy)
                    queue_tick(random_tick(line));
                else
                    queue_tick(make_tick(1'b0, OP_RESET, 8'h00, line));
            end
        end
        wait (expected_outputs.size() == 0);
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] wd, input int line,
                           input bit noisy);
        queue_tick(make_tick(1'b1, op, wd, line));
        drain_to_idle(noisy, line);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CLOCKS_PER_US:     bus_cfg.clocks_per_us     = val[7:0];
            REG_RESET_LOW_US:      bus_cfg.reset_low_us      = val;
            REG_PRESENCE_WAIT_US:  bus_cfg.presence_wait_us  = val;
            REG_RESET_RECOVERY_US: bus_cfg.reset_recovery_us = val;
            REG_SHORT_LOW_US:      bus_cfg.short_low_us      = val;
            REG_LONG_LOW_US:       bus_cfg.long_low_us       = val;
            REG_READ_SAMPLE_US:    bus_cfg.read_sample_us    = val;
            REG_READ_TAIL_US:      bus_cfg.read_tail_us      = val;
            default: ;
        endcase
    endtask

    task automatic load_timing(input int cpu, input int rst_low, input int pres_wait,
                               input int rec, input int short_low, input int long_low,
                               input int sample, input int tail);
        write_reg(REG_CLOCKS_PER_US, CFG_DATA_W'(cpu));
        write_reg(REG_RESET_LOW_US, CFG_DATA_W'(rst_low));
        write_reg(REG_PRESENCE_WAIT_US, CFG_DATA_W'(pres_wait));
        write_reg(REG_RESET_RECOVERY_US, CFG_DATA_W'(rec));
        write_reg(REG_SHORT_LOW_US, CFG_DATA_W'(short_low));
        write_reg(REG_LONG_LOW_US, CFG_DATA_W'(long_low));
        write_reg(REG_READ_SAMPLE_US, CFG_DATA_W'(sample));
        write_reg(REG_READ_TAIL_US, CFG_DATA_W'(tail));
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Tick source
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_outputs.push_back(bus_tick(tick_on_bus));
                ticks_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_hold > 0)
                begin
                    tx_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    tick_on_bus = pending_ticks.pop_front();
                    s_tdata  <= {{(IN_W - $bits(tick_t)){1'b0}}, tick_on_bus};
                    s_tvalid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 11) == 0)
                        tx_hold = $urandom_range(1, 14);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output checker with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $error("output transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    got  = res_t'(m_tdata[RES_W-1:0]);
                    check_field("drive_low", want.drive_low, got.drive_low);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("presence", want.presence, got.presence);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("crc_value", want.crc_value, got.crc_value);
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 11) == 0)
                    rx_hold = $urandom_range(1, 14);
            end
        end
    end

    // Abort if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        ticks_queued = 0;
        ticks_taken  = 0;
        mismatches   = 0;
        tx_hold      = 0;
        rx_hold      = 0;
        idle_cycles  = 0;
        gaps_on      = 1'b1;

        bus_cfg = '{clocks_per_us: 8, reset_low_us: 480, presence_wait_us: 70,
                    reset_recovery_us: 410, short_low_us: 2, long_low_us: 60,
                    read_sample_us: 10, read_tail_us: 50};
        ph      = PH_IDLE;
        presc   = '0;
        usc     = '0;
        bit_idx = '0;
        shreg   = '0;
        crc     = '0;
        last_rd = '0;
        pres    = 1'b0;
        cur_op  = OP_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Unmapped indexes must leave the timing alone
        write_reg(REG_UNMAPPED, 10'h3FF);
        write_reg(REG_LAST + 4'd1, 10'h000);

        // Default slot durations at one tick per microsecond
        write_reg(REG_CLOCKS_PER_US, 10'd1);
        run_cmd(OP_RBIT, 8'h00, 1, 1'b0);

        // Fastest timing for the directed commands
        load_timing(1, 1, 1, 1, 1, 1, 1, 1);
        run_cmd(OP_RESET, 8'h00, 0, 1'b0);
        run_cmd(OP_RESET, 8'hFF, 1, 1'b0);
        run_cmd(OP_WBYTE, 8'hFF, 1, 1'b0);
        run_cmd(OP_WBYTE, 8'h00, 0, 1'b0);
        run_cmd(OP_WBIT, 8'h01, 1, 1'b0);
        run_cmd(OP_WBIT, 8'hFE, 0, 1'b0);
        run_cmd(OP_RBYTE, 8'h00, 1, 1'b0);
        run_cmd(OP_RBYTE, 8'hFF, 0, 1'b0);
        run_cmd(OP_RBIT, 8'h00, 1, 1'b0);
        run_cmd(OP_RBIT, 8'h00, 0, 1'b0);
        for (int k = 1; k <= 3; k++)
            run_cmd(3'(OP_RBIT + k), 8'hA5, LINE_RANDOM, 1'b0);
        // Commands arriving mid-slot must be dropped
        run_cmd(OP_RBYTE, 8'h5A, LINE_RANDOM, 1'b1);
        run_cmd(OP_WBYTE, 8'hC3, LINE_RANDOM, 1'b1);

        // Zero prescale and zero durations count as one
        load_timing(0, 0, 0, 0, 0, 0, 0, 0);
        run_cmd(OP_RESET, 8'h00, LINE_RANDOM, 1'b0);
        run_cmd(OP_RBYTE, 8'h00, LINE_RANDOM, 1'b0);

        // Slower prescale with shortest durations
        load_timing(5, 1, 1, 1, 1, 1, 1, 1);
        run_cmd(OP_RESET, 8'h00, 1, 1'b0);
        run_cmd(OP_WBIT, 8'h00, 0, 1'b0);

        // Random tick streams under random short timing
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_timing($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                        $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                        $urandom_range(1, 2), $urandom_range(1, 2));
            if (p == RANDOM_PHASES - 1)
                gaps_on = 1'b0;
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                queue_tick(random_tick(LINE_RANDOM));
                // Hold the source once until the output side has caught up
                if (p == 1 && n == TICKS_PER_PHASE / 2)
                begin
                    wait (ticks_taken == ticks_queued);
                    wait (expected_outputs.size() == 0);
                end
            end
            drain_to_idle(1'b1, LINE_RANDOM);
        end

        wait (ticks_taken == ticks_queued);
        wait (expected_outputs.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
